>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions clocked on clk with arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Property that must hold even while reset is asserted.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/lpfp_pkg.sv
// ----------------------------------------------------------------------------
// lpfp_pkg
// Types and constants shared by the length-prefixed frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfp_pkg;

	localparam int HEADER_BYTES = 20;
	localparam int LEN_END      = 4;
	localparam int MSG_END      = 8;
	localparam int SEQ_END      = 12;

	localparam int QUEUE_DEPTH  = 2;
	localparam int APB_ADDR_W   = 3;
	localparam int APB_DATA_W   = 32;
	localparam int CFG_W        = 16;
	localparam logic [CFG_W-1:0] MAX_FRAME_RESET = 16'hFFFF;

	localparam int TDATA_W      = 152;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_BODY   = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [31:0]        message_id;
		logic [31:0]        sequence_id;
		logic signed [63:0] sender_id;
		logic [15:0]        body_length;
		logic [7:0]         body_byte;
		logic               last;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

`default_nettype wire

>>> rtl/lpfp_front.sv
// ----------------------------------------------------------------------------
// lpfp_front
// Accepts stream bytes, tracks header and body position, and classifies
// the last header byte and each body byte into a header, body or error record.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfp_front (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    byte_valid,
	output logic                         byte_ready,
	input  wire logic [7:0]              stream_byte,
	input  wire logic [15:0]             max_frame_bytes,
	input  wire lpfp_pkg::qstat_t        qstat,
	output logic                         push,
	output lpfp_pkg::item_t              item
);
	import lpfp_pkg::*;

	logic [4:0]  header_count_q;
	logic [31:0] length_shift_q;
	logic [31:0] message_shift_q;
	logic [31:0] sequence_shift_q;
	logic [63:0] sender_shift_q;
	logic [15:0] body_remaining_q;
	logic        stuck_error_q;

	logic        accept;
	logic        work;
	logic        in_body;
	logic        hdr_done;
	logic        bad_len;
	logic [63:0] sender_next;

	assign byte_ready  = !qstat.full;
	assign accept      = byte_valid && byte_ready;
	assign work        = accept && !stuck_error_q;
	assign in_body     = body_remaining_q != 16'd0;
	assign hdr_done    = header_count_q == 5'(HEADER_BYTES - 1);
	assign sender_next = {sender_shift_q[55:0], stream_byte};
	assign bad_len     = (length_shift_q < 32'(HEADER_BYTES)) ||
		(length_shift_q > {16'd0, max_frame_bytes});

	always_comb begin
		item = '0;
		push = 1'b0;
		if (work) begin
			if (in_body) begin
				push           = 1'b1;
				item.kind      = KIND_BODY;
				item.body_byte = stream_byte;
				item.last      = body_remaining_q == 16'd1;
			end else if (hdr_done) begin
				push = 1'b1;
				if (bad_len) begin
					item.kind = KIND_ERROR;
					item.last = 1'b1;
				end else begin
					item.kind        = KIND_HEADER;
					item.message_id  = message_shift_q;
					item.sequence_id = sequence_shift_q;
					item.sender_id   = sender_next;
					item.body_length = 16'(length_shift_q - 32'(HEADER_BYTES));
					item.last        = length_shift_q == 32'(HEADER_BYTES);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_count_q   <= '0;
			length_shift_q   <= '0;
			message_shift_q  <= '0;
			sequence_shift_q <= '0;
			sender_shift_q   <= '0;
			body_remaining_q <= '0;
			stuck_error_q    <= 1'b0;
		end else if (work) begin
			if (in_body) begin
				body_remaining_q <= body_remaining_q - 16'd1;
			end else begin
				if (header_count_q < 5'(LEN_END)) begin
					length_shift_q <= {length_shift_q[23:0], stream_byte};
				end else if (header_count_q < 5'(MSG_END)) begin
					message_shift_q <= {message_shift_q[23:0], stream_byte};
				end else if (header_count_q < 5'(SEQ_END)) begin
					sequence_shift_q <= {sequence_shift_q[23:0], stream_byte};
				end else begin
					sender_shift_q <= sender_next;
				end
				if (hdr_done) begin
					header_count_q <= '0;
					if (bad_len) begin
						stuck_error_q <= 1'b1;
					end else begin
						body_remaining_q <= 16'(length_shift_q - 32'(HEADER_BYTES));
					end
				end else begin
					header_count_q <= header_count_q + 5'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/lpfp_queue.sv
// ----------------------------------------------------------------------------
// lpfp_queue
// Short first-in first-out queue of classified records between the front
// and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfp_queue #(
	parameter int DEPTH = lpfp_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire lpfp_pkg::item_t  push_item,
	input  wire logic             pop,
	output lpfp_pkg::item_t       head_item,
	output lpfp_pkg::qstat_t      qstat
);
	import lpfp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t             mem [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign qstat.full  = count_q == CNT_W'(DEPTH);
	assign qstat.empty = count_q == '0;
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head_item   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/lpfp_back.sv
// ----------------------------------------------------------------------------
// lpfp_back
// Pulls records from the queue into the output register and presents them
// on the master stream.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfp_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lpfp_pkg::qstat_t              qstat,
	input  wire lpfp_pkg::item_t               head_item,
	output logic                               pop,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [lpfp_pkg::TDATA_W-1:0]       m_tdata,
	output lpfp_pkg::kind_t                    m_tuser,
	output logic                               m_tlast
);
	import lpfp_pkg::*;

	item_t out_q;
	logic  valid_q;

	assign pop      = !qstat.empty && (!valid_q || m_tready);
	assign m_tvalid = valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;
	assign m_tdata  = {out_q.body_byte, out_q.body_length, out_q.sender_id,
		out_q.sequence_id, out_q.message_id};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || m_tready) begin
			valid_q <= !qstat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= head_item;
		end
	end

endmodule

`default_nettype wire

>>> rtl/length_prefixed_frame_parser_core.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser_core
// Splits a byte stream into frames with a 20-byte big-endian header and
// emits a header beat, one beat per body byte, or a single error beat.
// ----------------------------------------------------------------------------
// The core takes one stream byte per cycle while s_tready is high and delivers
// up to one result beat per cycle. A byte is classified by the front in the
// cycle it is accepted and written into a two-entry queue; the back moves it
// from the queue into the output register once that register is empty or
// being taken. While the master side stalls, s_tready falls once the
// queue holds two beats behind the waiting output register. Header bytes other
// than the twentieth produce no beat. After a length below 20 or above
// max_frame_bytes the error beat is sent and all further bytes are dropped
// until reset. max_frame_bytes sits at byte address 0 of the APB port and is
// applied at the next length check.
`default_nettype none

module length_prefixed_frame_parser_core #(
	parameter int QUEUE_DEPTH = lpfp_pkg::QUEUE_DEPTH
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// Fields from bit 0: stream_byte[7:0].
	input  wire logic [7:0]                        s_tdata,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// Fields from bit 0: message_id[31:0], sequence_id[63:32],
	// sender_id[127:64], body_length[143:128], body_byte[151:144].
	output logic [lpfp_pkg::TDATA_W-1:0]           m_tdata,
	// Fields from bit 0: kind[1:0].
	output lpfp_pkg::kind_t                        m_tuser,
	output logic                                   m_tlast,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [lpfp_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [lpfp_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [lpfp_pkg::APB_DATA_W-1:0]        prdata,
	output logic                                   pready
);
	import lpfp_pkg::*;

	localparam logic REG_MAX_FRAME_BYTES = 1'b0;

	logic [CFG_W-1:0] max_frame_bytes_q;
	logic             cfg_write;
	logic             push;
	logic             pop;
	item_t            push_item;
	item_t            head_item;
	qstat_t           qstat;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[2])
			REG_MAX_FRAME_BYTES: prdata = {16'd0, max_frame_bytes_q};
			default:             prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_bytes_q <= MAX_FRAME_RESET;
		end else if (cfg_write && (paddr[2] == REG_MAX_FRAME_BYTES)) begin
			max_frame_bytes_q <= pwdata[CFG_W-1:0];
		end
	end

	lpfp_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_valid      (s_tvalid),
		.byte_ready      (s_tready),
		.stream_byte     (s_tdata),
		.max_frame_bytes (max_frame_bytes_q),
		.qstat           (qstat),
		.push            (push),
		.item            (push_item)
	);

	lpfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.qstat     (qstat)
	);

	lpfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.head_item (head_item),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

`include "assert_macros.svh"

	`ASSERT_CLK(a_no_push_when_full, qstat.full |-> !push, "Record pushed into a full queue.")
	`ASSERT_CLK(a_error_is_last, (m_tvalid && (m_tuser == KIND_ERROR)) |-> m_tlast, "Error beat without last.")
	`ASSERT_CLK(a_silent_after_error, (m_tvalid && m_tready && (m_tuser == KIND_ERROR)) |=> !m_tvalid, "Beat sent after the error beat.")
	`ASSERT_CLK(a_ready_tracks_queue, s_tready == !qstat.full, "Input ready disagrees with queue space.")

endmodule

`default_nettype wire
